@@ rtl/masked_ring_fifo_defines.svh @@
// assertion macros shared by the checker file
`ifndef MASKED_RING_FIFO_DEFINES_SVH
`define MASKED_RING_FIFO_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mrf_pkg.sv @@
// types and constants for the masked ring fifo
package mrf_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int MASK_W  = 6;
    localparam int LIMIT_W = 7;
    localparam int CMD_W   = 2;

    localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(63);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_DUMP  = 2'd3
    } t_cmd;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    typedef struct packed {
        logic              success;
        logic [WORD_W-1:0] read_value;
        logic              value_valid;
        logic [IDX_W-1:0]  fill_count;
        logic [MASK_W-1:0] free_space;
        logic              last;
    } t_result;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } t_ram_req;

endpackage

@@ rtl/masked_ring_fifo.sv @@
// masked ring fifo top level: command decode, indices, result register
// Ring FIFO of 16-bit words in a 64-entry memory addressed by (index AND ring_mask); at most
// ring_mask words are held. Push, flush and any command that returns no data load the result
// register at once; a pop takes its word in S_READ from the memory's registered read port. A
// dump issues its first read, then returns its entries from S_READ via that single port. The
// result register lets a new transaction be accepted as the previous result is taken. ring_mask
// has its own channel; the user must write it only while idle; the block does not check this.
module masked_ring_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mrf_pkg::CMD_W-1:0]     i_command,
    input  logic [mrf_pkg::WORD_W-1:0]    i_push_value,
    input  logic [mrf_pkg::LIMIT_W-1:0]   i_dump_limit,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_success,
    output logic [mrf_pkg::WORD_W-1:0]    o_read_value,
    output logic                          o_value_valid,
    output logic [mrf_pkg::IDX_W-1:0]     o_fill_count,
    output logic [mrf_pkg::MASK_W-1:0]    o_free_space,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mrf_pkg::MASK_W-1:0]    i_cfg_ring_mask
);

    mrf_pkg::t_state                 r_state, n_state;
    logic [mrf_pkg::IDX_W-1:0]       r_wr, n_wr;
    logic [mrf_pkg::IDX_W-1:0]       r_rd, n_rd;
    logic [mrf_pkg::IDX_W-1:0]       r_cur, n_cur;
    logic [mrf_pkg::IDX_W-1:0]       r_left, n_left;
    logic                            r_is_pop, n_is_pop;
    logic [mrf_pkg::MASK_W-1:0]      r_mask;
    logic                            r_out_valid, n_out_valid;
    mrf_pkg::t_result                r_out, n_out;

    mrf_pkg::t_ram_req               ram_req;
    logic [mrf_pkg::WORD_W-1:0]      ram_rd_data;

    logic                            out_free;
    logic                            load;
    logic [mrf_pkg::IDX_W-1:0]       fill_cur;
    logic [mrf_pkg::IDX_W-1:0]       fill_next;
    logic [mrf_pkg::LIMIT_W-1:0]     limit_m1;
    logic [mrf_pkg::LIMIT_W-1:0]     dump_n_wide;
    logic [mrf_pkg::IDX_W-1:0]       dump_n;

    mrf_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (ram_rd_data)
    );

    assign out_free    = !r_out_valid || i_ready;
    assign o_ready     = (r_state == mrf_pkg::S_IDLE) && out_free;
    assign o_cfg_ready = 1'b1;

    assign fill_cur = r_wr - r_rd;
    assign limit_m1 = (i_dump_limit >= mrf_pkg::LIMIT_W'(2))
                    ? (i_dump_limit - mrf_pkg::LIMIT_W'(1)) : '0;
    assign dump_n_wide = (limit_m1 > {1'b0, fill_cur}) ? {1'b0, fill_cur} : limit_m1;
    assign dump_n      = dump_n_wide[mrf_pkg::IDX_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_wr     = r_wr;
        n_rd     = r_rd;
        n_cur    = r_cur;
        n_left   = r_left;
        n_is_pop = r_is_pop;
        load     = 1'b0;
        ram_req  = '0;
        ram_req.wr_data = i_push_value;
        n_out    = r_out;
        n_out.success     = 1'b0;
        n_out.read_value  = '0;
        n_out.value_valid = 1'b0;
        n_out.last        = 1'b1;

        unique case (r_state)
            mrf_pkg::S_IDLE: begin
                if (i_valid && out_free) begin
                    unique case (mrf_pkg::t_cmd'(i_command))
                        mrf_pkg::CMD_PUSH: begin
                            if (fill_cur < r_mask) begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = r_wr & r_mask;
                                n_wr            = r_wr + mrf_pkg::IDX_W'(1);
                                n_out.success   = 1'b1;
                            end
                            load = 1'b1;
                        end
                        mrf_pkg::CMD_POP: begin
                            if (r_wr != r_rd) begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = r_rd & r_mask;
                                n_rd            = r_rd + mrf_pkg::IDX_W'(1);
                                n_is_pop        = 1'b1;
                                n_left          = mrf_pkg::IDX_W'(1);
                                n_state         = mrf_pkg::S_READ;
                            end else begin
                                load = 1'b1;
                            end
                        end
                        mrf_pkg::CMD_FLUSH: begin
                            n_wr = '0;
                            n_rd = '0;
                            load = 1'b1;
                        end
                        mrf_pkg::CMD_DUMP: begin
                            if (dump_n == '0) begin
                                load = 1'b1;
                            end else begin
                                // walk unread entries with a private cursor
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = r_rd & r_mask;
                                n_cur           = r_rd + mrf_pkg::IDX_W'(1);
                                n_is_pop        = 1'b0;
                                n_left          = dump_n;
                                n_state         = mrf_pkg::S_READ;
                            end
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            mrf_pkg::S_READ: begin
                if (out_free) begin
                    load              = 1'b1;
                    n_out.success     = r_is_pop;
                    n_out.value_valid = 1'b1;
                    n_out.read_value  = r_is_pop ? ram_rd_data
                                      : {{(mrf_pkg::WORD_W-mrf_pkg::BYTE_W){1'b0}},
                                         ram_rd_data[mrf_pkg::BYTE_W-1:0]};
                    n_out.last        = (r_left == mrf_pkg::IDX_W'(1));
                    if (r_left != mrf_pkg::IDX_W'(1)) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = r_cur & r_mask;
                        n_cur           = r_cur + mrf_pkg::IDX_W'(1);
                        n_left          = r_left - mrf_pkg::IDX_W'(1);
                    end else begin
                        n_state = mrf_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = mrf_pkg::S_IDLE;
            end
        endcase

        fill_next        = n_wr - n_rd;
        n_out.fill_count = fill_next;
        n_out.free_space = (r_mask > fill_next) ? (r_mask - fill_next) : '0;

        n_out_valid = load || (r_out_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrf_pkg::S_IDLE;
            r_wr        <= '0;
            r_rd        <= '0;
            r_mask      <= mrf_pkg::MASK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_mask <= i_cfg_ring_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_left   <= n_left;
        r_is_pop <= n_is_pop;
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_success     = r_out.success;
    assign o_read_value  = r_out.read_value;
    assign o_value_valid = r_out.value_valid;
    assign o_fill_count  = r_out.fill_count;
    assign o_free_space  = r_out.free_space;
    assign o_last        = r_out.last;

endmodule

@@ rtl/mrf_ram.sv @@
// ring storage: one write port, one read port with registered data
module mrf_ram (
    input  logic                         i_clk,
    input  mrf_pkg::t_ram_req            i_req,
    output logic [mrf_pkg::WORD_W-1:0]   o_rd_data
);

    logic [mrf_pkg::WORD_W-1:0] r_mem [mrf_pkg::DEPTH];
    logic [mrf_pkg::WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read data holds until the next read, so a stalled consumer keeps it
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/mrf_checker.sv @@
// port-level checks for the masked ring fifo, bound to the top level
`include "masked_ring_fifo_defines.svh"

module mrf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic                          o_success,
    input logic [mrf_pkg::WORD_W-1:0]    o_read_value,
    input logic                          o_value_valid,
    input logic                          o_last
);

    // a result without data carries a zero word
    `MRF_ASSERT_NOW(a_no_data_zero, i_clk, i_rst_n, o_valid && !o_value_valid, o_read_value == '0, "result without data has nonzero read_value")

    // a pop gives exactly one result
    `MRF_ASSERT_NOW(a_pop_single, i_clk, i_rst_n, o_valid && o_success && o_value_valid, o_last, "pop result not marked last")

    // dumped entries are low bytes only
    `MRF_ASSERT_NOW(a_dump_byte, i_clk, i_rst_n, o_valid && o_value_valid && !o_success, o_read_value[mrf_pkg::WORD_W-1:mrf_pkg::BYTE_W] == '0, "dumped entry wider than a byte")

    // a stalled result transaction holds
    `MRF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_read_value) && $stable(o_last), "stalled result changed")

endmodule

bind masked_ring_fifo mrf_checker u_mrf_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the masked ring fifo: random bursts, stalls and mask changes
module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 21;
    localparam int MAX_PRINTS   = 50;
    localparam int RX_ALWAYS    = 0;
    localparam int RX_RANDOM    = 1;
    localparam int RX_SPARSE    = 2;

    typedef struct {
        mrf_pkg::t_cmd               cmd;
        logic [mrf_pkg::WORD_W-1:0]  value;
        logic [mrf_pkg::LIMIT_W-1:0] limit;
    } t_item;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_valid         = 1'b0;
    logic                          o_ready;
    logic [mrf_pkg::CMD_W-1:0]     i_command       = '0;
    logic [mrf_pkg::WORD_W-1:0]    i_push_value    = '0;
    logic [mrf_pkg::LIMIT_W-1:0]   i_dump_limit    = '0;
    logic                          o_valid;
    logic                          i_ready         = 1'b0;
    logic                          o_success;
    logic [mrf_pkg::WORD_W-1:0]    o_read_value;
    logic                          o_value_valid;
    logic [mrf_pkg::IDX_W-1:0]     o_fill_count;
    logic [mrf_pkg::MASK_W-1:0]    o_free_space;
    logic                          o_last;
    logic                          i_cfg_valid     = 1'b0;
    logic                          o_cfg_ready;
    logic [mrf_pkg::MASK_W-1:0]    i_cfg_ring_mask = '0;

    masked_ring_fifo DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_push_value    (i_push_value),
        .i_dump_limit    (i_dump_limit),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_success       (o_success),
        .o_read_value    (o_read_value),
        .o_value_valid   (o_value_valid),
        .o_fill_count    (o_fill_count),
        .o_free_space    (o_free_space),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_ring_mask (i_cfg_ring_mask)
    );

    // shadow copy of the fifo
    logic [mrf_pkg::IDX_W-1:0]  wr_ptr      = '0;
    logic [mrf_pkg::IDX_W-1:0]  rd_ptr      = '0;
    logic [mrf_pkg::MASK_W-1:0] mask_shadow = mrf_pkg::MASK_RESET;
    logic [mrf_pkg::WORD_W-1:0] ring_shadow [mrf_pkg::DEPTH];

    t_item            cmd_q   [$];
    mrf_pkg::t_result reply_q [$];

    int   err_count   = 0;
    int   result_cnt  = 0;
    int   cycle_cnt   = 0;
    int   burst_left  = 0;
    int   gap_left    = 0;
    int   rx_tick     = 0;
    int   rx_mode     = RX_ALWAYS;
    int   hold_cnt    = 0;
    logic rx_hold     = 1'b0;
    logic hold_go     = 1'b0;
    logic in_accepted = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic mrf_pkg::t_result status_of(logic ok, logic [mrf_pkg::WORD_W-1:0] v,
                                                   logic vv, logic lst);
        mrf_pkg::t_result          r;
        logic [mrf_pkg::IDX_W-1:0] fill;
        fill          = wr_ptr - rd_ptr;
        r.success     = ok;
        r.read_value  = v;
        r.value_valid = vv;
        r.fill_count  = fill;
        r.free_space  = (mask_shadow > fill) ? mrf_pkg::MASK_W'(mask_shadow - fill) : '0;
        r.last        = lst;
        return r;
    endfunction

    task automatic apply_command(input t_item it);
        logic [mrf_pkg::IDX_W-1:0]  fill;
        logic [mrf_pkg::IDX_W-1:0]  cur;
        logic [mrf_pkg::BYTE_W-1:0] low_byte;
        int                         n;
        fill = wr_ptr - rd_ptr;
        case (it.cmd)
            mrf_pkg::CMD_PUSH: begin
                if (fill < mask_shadow) begin
                    ring_shadow[wr_ptr & mask_shadow] = it.value;
                    wr_ptr = wr_ptr + mrf_pkg::IDX_W'(1);
                    reply_q.push_back(status_of(1'b1, '0, 1'b0, 1'b1));
                end else begin
                    reply_q.push_back(status_of(1'b0, '0, 1'b0, 1'b1));
                end
            end
            mrf_pkg::CMD_POP: begin
                if (wr_ptr != rd_ptr) begin
                    cur    = rd_ptr;
                    rd_ptr = rd_ptr + mrf_pkg::IDX_W'(1);
                    reply_q.push_back(status_of(1'b1, ring_shadow[cur & mask_shadow], 1'b1, 1'b1));
                end else begin
                    reply_q.push_back(status_of(1'b0, '0, 1'b0, 1'b1));
                end
            end
            mrf_pkg::CMD_FLUSH: begin
                wr_ptr = '0;
                rd_ptr = '0;
                reply_q.push_back(status_of(1'b0, '0, 1'b0, 1'b1));
            end
            default: begin
                n = (it.limit >= 2) ? int'(it.limit) - 1 : 0;
                if (n > int'(fill))
                    n = int'(fill);
                if (n == 0) begin
                    reply_q.push_back(status_of(1'b0, '0, 1'b0, 1'b1));
                end else begin
                    cur = rd_ptr;
                    for (int k = 0; k < n; k++) begin
                        low_byte = ring_shadow[cur & mask_shadow][mrf_pkg::BYTE_W-1:0];
                        reply_q.push_back(status_of(1'b0,
                            {{(mrf_pkg::WORD_W-mrf_pkg::BYTE_W){1'b0}}, low_byte},
                            1'b1, k == n - 1));
                        cur = cur + mrf_pkg::IDX_W'(1);
                    end
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [mrf_pkg::WORD_W-1:0] got,
                                   input logic [mrf_pkg::WORD_W-1:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("mismatch on result %0d: %s got %h expected %h", result_cnt, what, got, want);
    endtask

    task automatic add_item(input mrf_pkg::t_cmd c, input logic [mrf_pkg::WORD_W-1:0] v,
                            input logic [mrf_pkg::LIMIT_W-1:0] lim);
        t_item it;
        it.cmd   = c;
        it.value = v;
        it.limit = lim;
        cmd_q.push_back(it);
    endtask

    function automatic t_item random_item(int push_pct);
        t_item it;
        int    roll;
        it.value = mrf_pkg::WORD_W'($urandom_range(0, 65535));
        it.limit = mrf_pkg::LIMIT_W'($urandom_range(0, 9));
        if ($urandom_range(0, 7) == 0)
            it.limit = mrf_pkg::LIMIT_W'($urandom_range(10, 64));
        if ($urandom_range(0, 31) == 0)
            it.limit = 7'd64;
        if ($urandom_range(0, 99) < push_pct) begin
            it.cmd = mrf_pkg::CMD_PUSH;
        end else begin
            roll = $urandom_range(0, 24);
            if (roll < 15)
                it.cmd = mrf_pkg::CMD_POP;
            else if (roll < 23)
                it.cmd = mrf_pkg::CMD_DUMP;
            else
                it.cmd = mrf_pkg::CMD_FLUSH;
        end
        return it;
    endfunction

    task automatic write_mask(input logic [mrf_pkg::MASK_W-1:0] m);
        @(negedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_cfg_ring_mask <= m;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        mask_shadow = m;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (cmd_q.size() > 0 || i_valid || reply_q.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [mrf_pkg::MASK_W-1:0] m, input int push_pct);
        write_mask(m);
        for (int i = 0; i < PHASE_ITEMS; i++)
            cmd_q.push_back(random_item(push_pct));
        wait_idle();
    endtask

    // sender: bursts of random length with random gaps
    always @(negedge i_clk) begin : send
        t_item nxt;
        if (i_rst_n && (in_accepted || !i_valid)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                nxt = cmd_q.pop_front();
                i_valid      <= 1'b1;
                i_command    <= nxt.cmd;
                i_push_value <= nxt.value;
                i_dump_limit <= nxt.limit;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: switches between always ready, coin flip and one cycle in four
    always @(negedge i_clk) begin : rx_drive
        logic take;
        rx_tick++;
        if (rx_tick % 50 == 0)
            rx_mode = $urandom_range(RX_ALWAYS, RX_SPARSE);
        case (rx_mode)
            RX_ALWAYS: take = 1'b1;
            RX_RANDOM: take = 1'($urandom_range(0, 1));
            default:   take = (rx_tick % 4 == 0);
        endcase
        i_ready <= take && !rx_hold;
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial begin
        wait (hold_go);
        rx_hold = 1'b1;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
            @(posedge i_clk);
        rx_hold = 1'b0;
    end

    always @(posedge i_clk) begin : watch
        mrf_pkg::t_result got;
        mrf_pkg::t_result want;
        t_item            seen;
        in_accepted = i_valid && o_ready;
        if (i_rst_n) begin
            if (in_accepted) begin
                seen.cmd   = mrf_pkg::t_cmd'(i_command);
                seen.value = i_push_value;
                seen.limit = i_dump_limit;
                apply_command(seen);
            end
            if (o_valid && i_ready) begin
                got = {o_success, o_read_value, o_value_valid, o_fill_count, o_free_space, o_last};
                if (reply_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding", got.read_value, '0);
                end else begin
                    want = reply_q.pop_front();
                    if (got.success !== want.success)
                        report_mismatch("success", mrf_pkg::WORD_W'(got.success),
                                        mrf_pkg::WORD_W'(want.success));
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", got.read_value, want.read_value);
                    if (got.value_valid !== want.value_valid)
                        report_mismatch("value_valid", mrf_pkg::WORD_W'(got.value_valid),
                                        mrf_pkg::WORD_W'(want.value_valid));
                    if (got.fill_count !== want.fill_count)
                        report_mismatch("fill_count", mrf_pkg::WORD_W'(got.fill_count),
                                        mrf_pkg::WORD_W'(want.fill_count));
                    if (got.free_space !== want.free_space)
                        report_mismatch("free_space", mrf_pkg::WORD_W'(got.free_space),
                                        mrf_pkg::WORD_W'(want.free_space));
                    if (got.last !== want.last)
                        report_mismatch("last", mrf_pkg::WORD_W'(got.last),
                                        mrf_pkg::WORD_W'(want.last));
                end
                result_cnt++;
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_mask(mrf_pkg::MASK_RESET);

        // fill to the brim, then cycle one more word so every slot has been written once
        for (int i = 0; i < 63; i++)
            add_item(mrf_pkg::CMD_PUSH, mrf_pkg::WORD_W'($urandom_range(0, 65535)), 7'd0);
        add_item(mrf_pkg::CMD_PUSH, 16'h5a5a, 7'd0);     // push into a full fifo
        add_item(mrf_pkg::CMD_DUMP, 16'h0000, 7'd64);    // widest dump
        add_item(mrf_pkg::CMD_POP,  16'h0000, 7'd0);
        add_item(mrf_pkg::CMD_PUSH, 16'hffff, 7'd0);
        add_item(mrf_pkg::CMD_DUMP, 16'hffff, 7'd1);     // limit too small to give anything
        add_item(mrf_pkg::CMD_DUMP, 16'h0000, 7'd0);
        add_item(mrf_pkg::CMD_DUMP, 16'h0000, 7'd2);
        add_item(mrf_pkg::CMD_FLUSH, 16'h0000, 7'd0);
        add_item(mrf_pkg::CMD_POP,  16'h0000, 7'd0);     // pop from empty
        add_item(mrf_pkg::CMD_DUMP, 16'h0000, 7'd5);     // dump from empty
        add_item(mrf_pkg::CMD_PUSH, 16'h0000, 7'd0);
        add_item(mrf_pkg::CMD_PUSH, 16'hffff, 7'd127);
        add_item(mrf_pkg::CMD_PUSH, 16'h80a5, 7'd0);
        add_item(mrf_pkg::CMD_DUMP, 16'h0000, 7'd3);
        add_item(mrf_pkg::CMD_DUMP, 16'h0000, 7'd64);
        for (int i = 0; i < 4; i++)
            add_item(mrf_pkg::CMD_POP, 16'h0000, 7'd0);
        wait_idle();

        // the first phase runs under the receiver hold-off; the next lowers the mask under the fill
        hold_go = 1'b1;
        run_phase(6'd63, 70);
        run_phase(6'd7,  40);
        run_phase(6'd1,  50);
        run_phase(6'd10, 50);
        run_phase(6'd31, 55);
        run_phase(6'd3,  45);
        run_phase(6'd15, 50);
        run_phase(6'd63, 35);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mrf_pkg.sv
rtl/mrf_ram.sv
rtl/masked_ring_fifo.sv
rtl/mrf_checker.sv
verif/tb_top.sv
